// ----- hw/rtl/page_frame_bitmap_allocator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Frame allocator assertion macros
// Concurrent check wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/pfba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator package
// Field widths, operation codes and status codes shared by the allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

	localparam int FUNC_W   = 2;
	localparam int FRAME_W  = 10;
	localparam int PID_W    = 16;
	localparam int VPN_W    = 20;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;
	localparam int CFG_W    = 11;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	// operation codes; anything else acts as a query
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EVICT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_BUSY  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

endpackage

// ----- hw/rtl/page_frame_bitmap_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame bitmap allocator
// Occupancy bitmap, per-frame owner store and allocated count with a
// word-serial lowest-free-frame search.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, frames_in_use) sets the managed frame
//    count; cfg_ready is always high. Write it only while the block is idle.
//  - in channel carries one beat per operation (func, frame, page_pid,
//    page_vpn); out channel returns one result beat per operation.
//  - After accepting a beat the block runs: an update step (bitmap word and
//    owner entry read at accept), then a free search that reads one bitmap
//    word per cycle through the find-first-zero unit, then a step to post
//    the result.
//  - in_ready is high only in idle. The result sits in an output register, so
//    the next beat is taken while it waits; the block stalls before posting a
//    further result until out_ready drains the register.
//  - Reset clears the count and restores 1024 managed frames, then a clearing
//    pass zeroes the bitmap word by word with in_ready low. Owner entries
//    are not cleared.
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_top_defines.svh"

module page_frame_bitmap_allocator_top
	import pfba_pkg::*;
#(
	parameter int MAX_FRAMES    = 1024,
	parameter int MAP_WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    frames_in_use,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [FRAME_W-1:0]  frame,
	input  logic [PID_W-1:0]    page_pid,
	input  logic [VPN_W-1:0]    page_vpn,

	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [FRAME_W-1:0]  free_frame,
	output logic                no_free,
	output logic [COUNT_W-1:0]  allocated_frames,
	output logic                owner_valid,
	output logic [PID_W-1:0]    owner_pid,
	output logic [VPN_W-1:0]    owner_vpn
);

	localparam int WORDS  = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int IDX_W  = $clog2(MAX_FRAMES);
	localparam int BIT_W  = $clog2(MAP_WORD_BITS);
	localparam int NB_W   = $clog2(MAP_WORD_BITS + 1);
	localparam int LIM_W  = $clog2(WORDS * MAP_WORD_BITS + 1);
	localparam int CMP_W  = (LIM_W > FRAME_W) ? LIM_W : FRAME_W;
	localparam int OWN_W  = PID_W + VPN_W;

	// managed count after reset: the reset register value clamped to storage
	localparam logic [LIM_W-1:0] RESET_LIM =
		LIM_W'((int'(CFG_RESET) > MAX_FRAMES) ? MAX_FRAMES : int'(CFG_RESET));

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_UPD,
		S_SCAN,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [ADDR_W-1:0]    clr_q;
	logic [LIM_W-1:0]     limit_q;
	logic [COUNT_W-1:0]   alloc_cnt_q;

	// operation captured at accept
	logic [FUNC_W-1:0]    func_q;
	logic                 range_q;
	logic [ADDR_W-1:0]    word_q;
	logic [BIT_W-1:0]     bit_q;
	logic [IDX_W-1:0]     idx_q;
	logic [PID_W-1:0]     pid_q;
	logic [VPN_W-1:0]     vpn_q;

	// search sequencer
	logic [ADDR_W-1:0]    scan_w_q;
	logic [LIM_W-1:0]     scan_base_q;
	logic                 chk_s1;
	logic [LIM_W-1:0]     base_s1;

	// result under construction
	status_t              res_status_q;
	logic                 res_owner_valid_q;
	logic [PID_W-1:0]     res_pid_q;
	logic [VPN_W-1:0]     res_vpn_q;
	logic [FRAME_W-1:0]   res_free_q;
	logic                 res_no_free_q;

	// output register
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [FRAME_W-1:0]   out_free_q;
	logic                 out_no_free_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_owner_valid_q;
	logic [PID_W-1:0]     out_pid_q;
	logic [VPN_W-1:0]     out_vpn_q;

	// memories
	logic [MAP_WORD_BITS-1:0] map_mem [WORDS];
	logic [OWN_W-1:0]         own_mem [MAX_FRAMES];
	logic [MAP_WORD_BITS-1:0] map_rd_q;
	logic [OWN_W-1:0]         own_rd_q;

	logic                     map_we;
	logic [ADDR_W-1:0]        map_wa;
	logic [ADDR_W-1:0]        map_ra;
	logic [MAP_WORD_BITS-1:0] map_wd;
	logic                     own_we;

	logic                     in_beat;
	logic                     in_range_err;
	logic [ADDR_W-1:0]        in_word;

	logic                     occ;
	logic                     is_load;
	logic                     is_evict;
	logic                     upd_load_ok;
	logic                     upd_evict_ok;
	status_t                  upd_status;
	logic                     upd_owner_valid;

	logic                     scan_issue;
	logic [LIM_W-1:0]         rem;
	logic [NB_W-1:0]          nvalid;
	logic                     ffz_found;
	logic [BIT_W-1:0]         ffz_bit;
	logic [LIM_W-1:0]         found_frame;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_beat   = in_valid && in_ready;

	assign in_range_err = CMP_W'(frame) >= CMP_W'(limit_q);
	assign in_word      = ADDR_W'(frame / MAP_WORD_BITS);

	// ---- update step: decide the operation from the words read at accept
	assign occ      = map_rd_q[bit_q];
	assign is_load  = (func_q == FUNC_LOAD);
	assign is_evict = (func_q == FUNC_EVICT);

	assign upd_load_ok  = !range_q && is_load && !occ;
	assign upd_evict_ok = !range_q && is_evict && occ;
	// an in-range load always leaves the frame owned; otherwise the old owner shows
	assign upd_owner_valid = !range_q && (is_load || occ);

	always_comb begin
		if (range_q) begin
			upd_status = ST_RANGE;
		end else if (is_load && occ) begin
			upd_status = ST_BUSY;
		end else if (is_evict && !occ) begin
			upd_status = ST_EMPTY;
		end else begin
			upd_status = ST_OK;
		end
	end

	// ---- bitmap port muxing: clearing pass, update write-back, search reads
	always_comb begin
		map_we = 1'b0;
		map_wa = word_q;
		map_wd = map_rd_q;
		case (state_q)
			S_CLR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				map_wd = '0;
			end
			S_UPD: begin
				map_we        = upd_load_ok || upd_evict_ok;
				map_wd[bit_q] = upd_load_ok;
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	assign map_ra = (state_q == S_SCAN) ? scan_w_q : in_word;
	assign own_we = (state_q == S_UPD) && upd_load_ok;

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd_q <= map_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (own_we) begin
			own_mem[idx_q] <= {pid_q, vpn_q};
		end
		own_rd_q <= own_mem[IDX_W'(frame)];
	end

	// ---- search: issue one word per cycle, test the word read last cycle
	assign scan_issue = scan_base_q < limit_q;
	assign rem        = limit_q - base_s1;
	assign nvalid     = (rem >= LIM_W'(MAP_WORD_BITS)) ? NB_W'(MAP_WORD_BITS) : NB_W'(rem);

	pfba_ffz #(
		.WORD_BITS (MAP_WORD_BITS)
	) u_ffz (
		.word    (map_rd_q),
		.nvalid  (nvalid),
		.found   (ffz_found),
		.bit_idx (ffz_bit)
	);

	assign found_frame = base_s1 + LIM_W'(ffz_bit);

	// ---- sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_CLR;
			clr_q             <= '0;
			limit_q           <= RESET_LIM;
			alloc_cnt_q       <= '0;
			func_q            <= FUNC_QUERY;
			range_q           <= 1'b0;
			word_q            <= '0;
			bit_q             <= '0;
			idx_q             <= '0;
			pid_q             <= '0;
			vpn_q             <= '0;
			scan_w_q          <= '0;
			scan_base_q       <= '0;
			chk_s1            <= 1'b0;
			base_s1           <= '0;
			res_status_q      <= ST_OK;
			res_owner_valid_q <= 1'b0;
			res_pid_q         <= '0;
			res_vpn_q         <= '0;
			res_free_q        <= '0;
			res_no_free_q     <= 1'b0;
			out_valid_q       <= 1'b0;
			out_status_q      <= '0;
			out_free_q        <= '0;
			out_no_free_q     <= 1'b0;
			out_count_q       <= '0;
			out_owner_valid_q <= 1'b0;
			out_pid_q         <= '0;
			out_vpn_q         <= '0;
		end else begin
			// clamp the managed count to the storage size
			if (cfg_valid && cfg_ready) begin
				if (32'(frames_in_use) > 32'(MAX_FRAMES)) begin
					limit_q <= LIM_W'(MAX_FRAMES);
				end else begin
					limit_q <= LIM_W'(frames_in_use);
				end
			end

			// drop the held result once taken, unless a new one posts now
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					if (clr_q == ADDR_W'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end

				S_IDLE: begin
					if (in_beat) begin
						func_q  <= func;
						range_q <= in_range_err;
						word_q  <= in_word;
						bit_q   <= BIT_W'(frame % MAP_WORD_BITS);
						idx_q   <= IDX_W'(frame);
						pid_q   <= page_pid;
						vpn_q   <= page_vpn;
						state_q <= S_UPD;
					end
				end

				S_UPD: begin
					res_status_q      <= upd_status;
					res_owner_valid_q <= upd_owner_valid;
					if (!upd_owner_valid) begin
						res_pid_q <= '0;
						res_vpn_q <= '0;
					end else if (upd_load_ok) begin
						res_pid_q <= pid_q;
						res_vpn_q <= vpn_q;
					end else begin
						res_pid_q <= own_rd_q[OWN_W-1:VPN_W];
						res_vpn_q <= own_rd_q[VPN_W-1:0];
					end
					if (upd_load_ok) begin
						alloc_cnt_q <= alloc_cnt_q + 1'b1;
					end else if (upd_evict_ok && (alloc_cnt_q != '0)) begin
						alloc_cnt_q <= alloc_cnt_q - 1'b1;
					end
					scan_w_q    <= '0;
					scan_base_q <= '0;
					chk_s1      <= 1'b0;
					state_q     <= S_SCAN;
				end

				S_SCAN: begin
					if (chk_s1 && ffz_found) begin
						res_free_q    <= FRAME_W'(found_frame);
						res_no_free_q <= 1'b0;
						state_q       <= S_DONE;
					end else if (!scan_issue) begin
						res_free_q    <= '0;
						res_no_free_q <= 1'b1;
						state_q       <= S_DONE;
					end else begin
						chk_s1      <= 1'b1;
						base_s1     <= scan_base_q;
						scan_w_q    <= scan_w_q + 1'b1;
						scan_base_q <= scan_base_q + LIM_W'(MAP_WORD_BITS);
					end
				end

				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q       <= 1'b1;
						out_status_q      <= res_status_q;
						out_free_q        <= res_free_q;
						out_no_free_q     <= res_no_free_q;
						out_count_q       <= alloc_cnt_q;
						out_owner_valid_q <= res_owner_valid_q;
						out_pid_q         <= res_pid_q;
						out_vpn_q         <= res_vpn_q;
						state_q           <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign free_frame       = out_free_q;
	assign no_free          = out_no_free_q;
	assign allocated_frames = out_count_q;
	assign owner_valid      = out_owner_valid_q;
	assign owner_pid        = out_pid_q;
	assign owner_vpn        = out_vpn_q;

	// ---- checks
	`PFBA_ASSERT_IMP(a_clr_blocks_input, clk, arst_n, state_q == S_CLR, !in_ready,
		"input taken during clearing pass")
	`PFBA_ASSERT_NXT(a_load_counts, clk, arst_n, (state_q == S_UPD) && upd_load_ok,
		alloc_cnt_q == COUNT_W'($past(alloc_cnt_q) + 1'b1), "load did not bump the count")
	`PFBA_ASSERT_IMP(a_free_in_range, clk, arst_n, (state_q == S_DONE) && !res_no_free_q,
		CMP_W'(res_free_q) < CMP_W'(limit_q), "free frame beyond managed range")
	`PFBA_ASSERT_IMP(a_owner_zero, clk, arst_n, out_valid_q && !out_owner_valid_q,
		(out_pid_q == '0) && (out_vpn_q == '0), "owner fields set without an owner")

endmodule

// ----- hw/rtl/pfba_ffz.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Find-first-zero unit
// Lowest clear bit among the low nvalid bits of one bitmap word.
// ----------------------------------------------------------------------------
module pfba_ffz #(
	parameter int  WORD_BITS = 32,
	localparam int BIT_W     = $clog2(WORD_BITS),
	localparam int NB_W      = $clog2(WORD_BITS + 1)
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [NB_W-1:0]      nvalid,
	output logic                 found,
	output logic [BIT_W-1:0]     bit_idx
);

	// scan downward so the lowest hit wins
	always_comb begin
		found   = 1'b0;
		bit_idx = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!word[b] && (NB_W'(b) < nvalid)) begin
				found   = 1'b1;
				bit_idx = BIT_W'(b);
			end
		end
	end

endmodule

// ----- tb/page_frame_bitmap_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Runs a scripted set of load, evict and query operations and then random
// traffic under a series of managed frame counts. Every result beat is
// compared field by field with a typed script result or a shadow copy of
// the bitmap, owner store and allocated count, updated on each accepted beat.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_top_tb;
	import pfba_pkg::*;

	localparam int FRAMES       = 1024;
	localparam int STALL_LIMIT  = 2000;  // cycles with no beat on any channel
	localparam int HOLD_CYCLES  = 400;   // long output back-pressure stretch
	localparam int TAIL_CYCLES  = 40;    // about one full free search
	localparam int N_PHASES     = 14;
	localparam int PICK_RANDOM  = -1;    // phase draws a small frame count
	localparam int PICK_ANY     = -2;    // phase draws any nonzero register value

	// the spare operation code, which the block treats as a query
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct {
		status_t             status;
		logic [FRAME_W-1:0]  free_frame;
		logic                no_free;
		logic [COUNT_W-1:0]  allocated;
		logic                owner_valid;
		logic [PID_W-1:0]    owner_pid;
		logic [VPN_W-1:0]    owner_vpn;
	} frame_result_t;

	typedef struct {
		bit                  is_cfg;
		logic [CFG_W-1:0]    cfg_value;
		logic [FUNC_W-1:0]   func;
		logic [FRAME_W-1:0]  frame;
		logic [PID_W-1:0]    pid;
		logic [VPN_W-1:0]    vpn;
		bit                  typed;
		frame_result_t       res;
	} script_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic               cfg_valid  = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_frames = CFG_RESET;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [FUNC_W-1:0]  in_func  = FUNC_QUERY;
	logic [FRAME_W-1:0] in_frame = '0;
	logic [PID_W-1:0]   in_pid   = '0;
	logic [VPN_W-1:0]   in_vpn   = '0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] res_status;
	logic [FRAME_W-1:0]  res_free_frame;
	logic                res_no_free;
	logic [COUNT_W-1:0]  res_allocated;
	logic                res_owner_valid;
	logic [PID_W-1:0]    res_owner_pid;
	logic [VPN_W-1:0]    res_owner_vpn;

	// typed expectation riding along with the beat on the input channel
	bit            use_typed = 1'b0;
	frame_result_t typed_res;

	// shadow state of the allocator
	bit                 occ_map [FRAMES];
	logic [PID_W-1:0]   pid_mem [FRAMES];
	logic [VPN_W-1:0]   vpn_mem [FRAMES];
	logic [COUNT_W-1:0] alloc_count      = '0;
	logic [CFG_W-1:0]   frames_cfg_model = CFG_RESET;

	frame_result_t awaited_results[$];
	script_row_t   script[$];

	int fails = 0;
	int ops_seen [4];
	int status_seen [4];
	int full_seen = 0;
	int cfg_writes = 0;

	page_frame_bitmap_allocator_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.frames_in_use    (cfg_frames),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (in_func),
		.frame            (in_frame),
		.page_pid         (in_pid),
		.page_vpn         (in_vpn),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (res_status),
		.free_frame       (res_free_frame),
		.no_free          (res_no_free),
		.allocated_frames (res_allocated),
		.owner_valid      (res_owner_valid),
		.owner_pid        (res_owner_pid),
		.owner_vpn        (res_owner_vpn)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Shadow allocator
	// ------------------------------------------------------------------------

	// register values above the bitmap size clamp to the full bitmap
	function automatic int managed_count();
		return (frames_cfg_model > FRAMES) ? FRAMES : int'(frames_cfg_model);
	endfunction

	// lowest free managed frame, or -1 when every managed frame is taken
	function automatic int lowest_free(input int m);
		for (int i = 0; i < m; i++)
			if (!occ_map[i])
				return i;
		return -1;
	endfunction

	// some occupied managed frame, starting from a random point
	function automatic int pick_occupied(input int m);
		int start;
		int i;
		if (m == 0)
			return -1;
		start = $urandom_range(0, m - 1);
		for (int k = 0; k < m; k++) begin
			i = (start + k) % m;
			if (occ_map[i])
				return i;
		end
		return -1;
	endfunction

	// apply one operation to the shadow state and return its result beat
	function automatic frame_result_t apply_frame_op(
		input logic [FUNC_W-1:0]  f,
		input logic [FRAME_W-1:0] fr,
		input logic [PID_W-1:0]   pid,
		input logic [VPN_W-1:0]   vpn
	);
		frame_result_t r;
		int m;
		int ff;
		m = managed_count();
		r.status      = ST_OK;
		r.owner_valid = 1'b0;
		r.owner_pid   = '0;
		r.owner_vpn   = '0;
		if (fr >= m) begin
			r.status = ST_RANGE;
		end else if (f == FUNC_LOAD) begin
			if (occ_map[fr]) begin
				r.status = ST_BUSY;
			end else begin
				occ_map[fr] = 1'b1;
				pid_mem[fr] = pid;
				vpn_mem[fr] = vpn;
				alloc_count = alloc_count + 1'b1;
			end
			r.owner_valid = 1'b1;
			r.owner_pid   = pid_mem[fr];
			r.owner_vpn   = vpn_mem[fr];
		end else if (f == FUNC_EVICT) begin
			if (!occ_map[fr]) begin
				r.status = ST_EMPTY;
			end else begin
				r.owner_valid = 1'b1;
				r.owner_pid   = pid_mem[fr];
				r.owner_vpn   = vpn_mem[fr];
				occ_map[fr]   = 1'b0;
				if (alloc_count != 0)
					alloc_count = alloc_count - 1'b1;
			end
		end else if (occ_map[fr]) begin
			// query, or the spare code acting as one
			r.owner_valid = 1'b1;
			r.owner_pid   = pid_mem[fr];
			r.owner_vpn   = vpn_mem[fr];
		end
		ff = lowest_free(m);
		r.no_free    = (ff < 0);
		r.free_frame = (ff < 0) ? '0 : ff[FRAME_W-1:0];
		r.allocated  = alloc_count;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Monitor: sample all three channels at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		frame_result_t want;
		frame_result_t pred;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				frames_cfg_model = cfg_frames;
				cfg_writes++;
			end
			// drain first: a result can never belong to a beat taken this edge
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with no operation pending (status %0d)",
						res_status);
					fails++;
				end else begin
					want = awaited_results.pop_front();
					check_field("status", want.status, res_status);
					check_field("free_frame", want.free_frame, res_free_frame);
					check_field("no_free", want.no_free, res_no_free);
					check_field("allocated_frames", want.allocated, res_allocated);
					check_field("owner_valid", want.owner_valid, res_owner_valid);
					check_field("owner_pid", want.owner_pid, res_owner_pid);
					check_field("owner_vpn", want.owner_vpn, res_owner_vpn);
				end
			end
			if (in_valid && in_ready) begin
				pred = apply_frame_op(in_func, in_frame, in_pid, in_vpn);
				want = use_typed ? typed_res : pred;
				awaited_results.push_back(want);
				ops_seen[in_func]++;
				status_seen[want.status]++;
				if (want.no_free)
					full_seen++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: give up after a long stretch with no beat anywhere
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("page_frame_bitmap_allocator_top_tb NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result sink: random stalls, quiet stretches, and two long hold-offs
	// that let the block fill its output register and stall its input
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int hold;
		int beats;
		bit quiet;
		beats = 0;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (beats % 32 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (beats == 150 || beats == 700)
				hold = HOLD_CYCLES;
			else
				hold = quiet ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			beats++;
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	bit tx_steady = 1'b0;

	// offer one beat after a random gap, or none in steady mode; return at the
	// falling edge after it is taken, with valid still high
	task automatic send_op(
		input logic [FUNC_W-1:0]  f,
		input logic [FRAME_W-1:0] fr,
		input logic [PID_W-1:0]   pid,
		input logic [VPN_W-1:0]   vpn,
		input bit                 typed,
		input frame_result_t      res
	);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_func   <= f;
		in_frame  <= fr;
		in_pid    <= pid;
		in_vpn    <= vpn;
		use_typed <= typed;
		typed_res <= res;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	// write the frame count only once the block has gone idle
	task automatic write_frames_cfg(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0 || !in_ready)
			@(negedge clk);
		cfg_frames <= v;
		cfg_valid  <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_cfg(input logic [CFG_W-1:0] v);
		script_row_t row;
		row.is_cfg    = 1'b1;
		row.cfg_value = v;
		row.func      = FUNC_QUERY;
		row.frame     = '0;
		row.pid       = '0;
		row.vpn       = '0;
		row.typed     = 1'b0;
		script.push_back(row);
	endtask

	task automatic add_op(
		input logic [FUNC_W-1:0]  f,
		input logic [FRAME_W-1:0] fr,
		input logic [PID_W-1:0]   pid,
		input logic [VPN_W-1:0]   vpn,
		input bit                 typed = 1'b0,
		input status_t            st = ST_OK,
		input int                 ff = 0,
		input bit                 nf = 1'b0,
		input int                 cnt = 0,
		input bit                 ov = 1'b0,
		input logic [PID_W-1:0]   opid = '0,
		input logic [VPN_W-1:0]   ovpn = '0
	);
		script_row_t row;
		row.is_cfg             = 1'b0;
		row.cfg_value          = '0;
		row.func               = f;
		row.frame              = fr;
		row.pid                = pid;
		row.vpn                = vpn;
		row.typed              = typed;
		row.res.status         = st;
		row.res.free_frame     = ff[FRAME_W-1:0];
		row.res.no_free        = nf;
		row.res.allocated      = cnt[COUNT_W-1:0];
		row.res.owner_valid    = ov;
		row.res.owner_pid      = opid;
		row.res.owner_vpn      = ovpn;
		script.push_back(row);
	endtask

	initial begin : stimulus
		int phase_cfg [N_PHASES];
		int v;
		int m;
		int n_items;
		int pick;
		int hit;
		int load_pct;
		int evict_pct;
		logic [FUNC_W-1:0]  f;
		logic [FRAME_W-1:0] fr;
		logic [PID_W-1:0]   pid;
		logic [VPN_W-1:0]   vpn;
		frame_result_t      blank;

		blank = '{ST_OK, '0, 1'b0, '0, 1'b0, '0, '0};

		// After reset: empty map, 1024 frames managed.
		add_op(FUNC_QUERY, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0);
		add_op(FUNC_EVICT, 0, 16'h1357, 20'h2468, 1, ST_EMPTY, 0, 0, 0, 0);
		add_op(FUNC_LOAD, 0, 16'hFFFF, 20'hFFFFF, 1, ST_OK, 1, 0, 1, 1,
			16'hFFFF, 20'hFFFFF);
		// load into a busy frame shows the old owner
		add_op(FUNC_LOAD, 0, 0, 0, 1, ST_BUSY, 1, 0, 1, 1, 16'hFFFF, 20'hFFFFF);
		add_op(FUNC_LOAD, 1023, 0, 0, 1, ST_OK, 1, 0, 2, 1, 0, 0);
		// the spare code acts as a query
		add_op(FUNC_SPARE, 1023, 16'hFFFF, 20'hFFFFF, 1, ST_OK, 1, 0, 2, 1, 0, 0);
		add_op(FUNC_EVICT, 0, 0, 0, 1, ST_OK, 0, 0, 1, 1, 16'hFFFF, 20'hFFFFF);
		add_op(FUNC_LOAD, 1, 16'hA5A5, 20'h5A5A5);
		add_op(FUNC_QUERY, 1, 0, 0);
		// a single managed frame: frame 1 stays occupied but is out of range
		add_cfg(1);
		add_op(FUNC_LOAD, 0, 1, 2, 1, ST_OK, 0, 1, 3, 1, 1, 2);
		add_op(FUNC_QUERY, 1, 0, 0, 1, ST_RANGE, 0, 1, 3, 0);
		add_op(FUNC_EVICT, 0, 0, 0, 1, ST_OK, 0, 0, 2, 1, 1, 2);
		// no managed frames at all
		add_cfg(0);
		add_op(FUNC_QUERY, 0, 0, 0, 1, ST_RANGE, 0, 1, 2, 0);
		add_op(FUNC_LOAD, 0, 16'hBEEF, 20'h12345, 1, ST_RANGE, 0, 1, 2, 0);
		// oversized register clamps to the full bitmap
		add_cfg(11'h7FF);
		add_op(FUNC_QUERY, 1023, 0, 0, 1, ST_OK, 0, 0, 2, 1, 0, 0);
		add_op(FUNC_EVICT, 1, 0, 0);
		// partial last bitmap word
		add_cfg(33);
		add_op(FUNC_LOAD, 32, 7, 9);
		add_op(FUNC_QUERY, 33, 0, 0);
		add_op(FUNC_EVICT, 1023, 0, 0);
		add_cfg(1024);

		phase_cfg = '{64, 32, 1, 40, 1024, 0, 2047, 97, 33, PICK_RANDOM, 200, 5,
			1000, PICK_ANY};

		// hold reset, then release between edges
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// the first write waits out the bitmap clearing pass
		write_frames_cfg(CFG_RESET);

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_frames_cfg(script[i].cfg_value);
			else
				send_op(script[i].func, script[i].frame, script[i].pid,
					script[i].vpn, script[i].typed, script[i].res);
		end

		// Random phases. Most beats are loads into the lowest free frame and
		// evicts of occupied frames so the map fills and drains; the rest are
		// busy loads, empty evicts, queries and random noise.
		for (int p = 0; p < N_PHASES; p++) begin
			if (phase_cfg[p] == PICK_RANDOM)
				v = $urandom_range(2, 300);
			else if (phase_cfg[p] == PICK_ANY)
				v = $urandom_range(1, 2047);
			else
				v = phase_cfg[p];
			write_frames_cfg(v[CFG_W-1:0]);
			m = managed_count();
			n_items = (m == 0) ? 12 : (m == FRAMES) ? 150 : 100;
			load_pct  = (p % 2 == 0) ? 60 : 35;
			evict_pct = (p % 2 == 0) ? 20 : 45;
			tx_steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < n_items; k++) begin
				pick = $urandom_range(0, 99);
				pid  = PID_W'($urandom);
				vpn  = VPN_W'($urandom);
				if (m == 0 || pick < 6) begin
					f  = FUNC_W'($urandom);
					fr = FRAME_W'($urandom);
				end else if (pick < 6 + load_pct) begin
					f   = FUNC_LOAD;
					hit = lowest_free(m);
					if (hit >= 0 && $urandom_range(0, 2) != 0)
						fr = FRAME_W'(hit);
					else
						fr = FRAME_W'($urandom_range(0, m - 1));
				end else if (pick < 6 + load_pct + evict_pct) begin
					f   = FUNC_EVICT;
					hit = pick_occupied(m);
					if (hit >= 0 && $urandom_range(0, 4) != 0)
						fr = FRAME_W'(hit);
					else
						fr = FRAME_W'($urandom_range(0, m - 1));
				end else begin
					f  = ($urandom_range(0, 4) == 0) ? FUNC_SPARE : FUNC_QUERY;
					fr = FRAME_W'($urandom_range(0, m - 1));
				end
				send_op(f, fr, pid, vpn, 1'b0, blank);
			end
		end

		// drop valid, drain, then allow one more search time for strays
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d loads, %0d evicts, %0d queries, %0d spare beats, %0d count writes",
			ops_seen[FUNC_LOAD], ops_seen[FUNC_EVICT], ops_seen[FUNC_QUERY],
			ops_seen[FUNC_SPARE], cfg_writes);
		$display("statuses ok/range/busy/empty %0d/%0d/%0d/%0d, %0d with a full map",
			status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_BUSY],
			status_seen[ST_EMPTY], full_seen);
		if (fails == 0)
			$display("page_frame_bitmap_allocator_top_tb OK");
		else
			$display("page_frame_bitmap_allocator_top_tb NOT OK");
		$finish;
	end

endmodule
